>>> rtl/csrc16_pkg.sv
// package: item kinds, result flags and the crc-16 xor network for the config stream receiver
package csrc16_pkg;

	typedef enum logic [2:0] {
		KIND_SET_HASH = 3'd0,
		KIND_START    = 3'd1,
		KIND_DATA     = 3'd2,
		KIND_ERROR    = 3'd3,
		KIND_REQUEST  = 3'd4
	} kind_t;

	// flags in m_tuser, accepted in the lowest bit
	typedef struct packed {
		logic stream_ok;
		logic payload_valid;
		logic accepted;
	} flags_t;

	localparam logic [15:0] CrcPoly   = 16'h1021;
	localparam logic [15:0] CrcPreset = 16'hFFFF;
	localparam logic [31:0] LenAll    = 32'hFFFF_FFFF;
	localparam logic [31:0] LenStep   = 32'd8;

	// each crc output bit as a mask over {crc, data}, built once at elaboration
	function automatic logic [15:0][79:0] crc_mask_gen();
		logic [15:0][79:0] m;
		logic [79:0] v;
		logic [15:0] r;
		logic fb;
		m = '0;
		for (int j = 0; j < 80; j++) begin
			v = '0;
			v[j] = 1'b1;
			r = v[79:64];
			// msb first over the whole frame is the same as byte by byte, first byte first
			for (int k = 63; k >= 0; k--) begin
				fb = r[15] ^ v[k];
				r = {r[14:0], 1'b0};
				if (fb) begin
					r = r ^ CrcPoly;
				end
			end
			for (int i = 0; i < 16; i++) begin
				m[i][j] = r[i];
			end
		end
		return m;
	endfunction

	localparam logic [15:0][79:0] CrcMask = crc_mask_gen();

	function automatic logic [15:0] crc_frame(input logic [15:0] acc, input logic [63:0] d);
		logic [79:0] v;
		logic [15:0] r;
		v = {acc, d};
		for (int i = 0; i < 16; i++) begin
			r[i] = ^(CrcMask[i] & v);
		end
		return r;
	endfunction

endpackage

>>> rtl/config_stream_receiver_crc16.sv
// top level: framed config stream receiver with crc-16 check
// path: an input transfer reaches the master side through the input register, then
// the result register, which is fed by the decode and crc xor network
// throughput: one item per cycle while the master side does not stall; the stream state updates as each item moves on
// reset: arst_n clears the valid flags and the stream state at once (disarmed,
// expected length all ones, crc preset); no clearing pass is needed
module config_stream_receiver_crc16 (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [127:0]             s_tdata,  // hash[15:0], stream_length[47:16], expected_crc[63:48], frame_data[127:64]
	input  logic [2:0]               s_tuser,  // kind[2:0]
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [95:0]              m_tdata,  // payload[63:0], computed_crc[79:64], report_hash[95:80]
	output csrc16_pkg::flags_t       m_tuser,  // accepted[0], payload_valid[1], stream_ok[2]
	output logic                     m_tlast   // stream_done
);
	import csrc16_pkg::*;

	// input register
	logic        valid_s1;
	logic [2:0]  kind_s1;
	logic [15:0] hash_s1;
	logic [31:0] slen_s1;
	logic [15:0] ecrc_s1;
	logic [63:0] data_s1;

	// result register
	logic        valid_s2;
	flags_t      flags_s2;
	logic        done_s2;
	logic [63:0] payload_s2;
	logic [15:0] crc_s2;
	logic [15:0] rhash_s2;

	// stream state
	logic        armed_q;
	logic [15:0] hash_exp_q;
	logic [31:0] len_exp_q;
	logic [31:0] len_rcv_q;
	logic [15:0] crc_exp_q;
	logic [15:0] crc_run_q;

	logic        armed_d;
	logic [15:0] hash_exp_d;
	logic [31:0] len_exp_d;
	logic [31:0] len_rcv_d;
	logic [15:0] crc_exp_d;
	logic [15:0] crc_run_d;
	flags_t      flags_d;
	logic        done_d;
	logic [63:0] payload_d;
	logic [15:0] crc_out_d;
	logic [15:0] rhash_d;

	logic        advance;
	logic        hash_match;
	logic [15:0] crc_frame_d;
	logic [31:0] len_sum;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	assign hash_match  = armed_q && (hash_s1 == hash_exp_q);
	assign crc_frame_d = crc_frame(crc_run_q, data_s1);
	assign len_sum     = (len_rcv_q > (LenAll - LenStep)) ? LenAll : (len_rcv_q + LenStep);

	always_comb begin
		armed_d    = armed_q;
		hash_exp_d = hash_exp_q;
		len_exp_d  = len_exp_q;
		len_rcv_d  = len_rcv_q;
		crc_exp_d  = crc_exp_q;
		crc_run_d  = crc_run_q;
		flags_d    = '0;
		done_d     = 1'b0;
		payload_d  = '0;
		crc_out_d  = crc_run_q;
		rhash_d    = (kind_s1 <= KIND_ERROR) ? hash_s1 : 16'd0;
		case (kind_s1)
			KIND_SET_HASH: begin
				hash_exp_d       = hash_s1;
				flags_d.accepted = 1'b1;
			end
			KIND_START: begin
				hash_exp_d       = hash_s1;
				len_exp_d        = slen_s1;
				len_rcv_d        = '0;
				crc_exp_d        = ecrc_s1;
				crc_run_d        = CrcPreset;
				armed_d          = 1'b1;
				flags_d.accepted = 1'b1;
				crc_out_d        = CrcPreset;
			end
			KIND_DATA: begin
				if (hash_match) begin
					flags_d.accepted      = 1'b1;
					flags_d.payload_valid = 1'b1;
					payload_d             = data_s1;
					crc_out_d             = crc_frame_d;
					if (len_sum >= len_exp_q) begin
						// stream complete: report the compared crc, then start over
						armed_d           = 1'b0;
						done_d            = 1'b1;
						flags_d.stream_ok = (crc_frame_d == crc_exp_q);
						len_rcv_d         = '0;
						crc_run_d         = CrcPreset;
					end else begin
						len_rcv_d = len_sum;
						crc_run_d = crc_frame_d;
					end
				end
			end
			KIND_ERROR: begin
				if (hash_match) begin
					armed_d          = 1'b0;
					len_exp_d        = '0;
					hash_exp_d       = '0;
					done_d           = 1'b1;
					flags_d.accepted = 1'b1;
				end
			end
			KIND_REQUEST: begin
				len_rcv_d        = '0;
				len_exp_d        = LenAll;
				crc_run_d        = CrcPreset;
				flags_d.accepted = 1'b1;
				crc_out_d        = CrcPreset;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			hash_s1 <= s_tdata[15:0];
			slen_s1 <= s_tdata[47:16];
			ecrc_s1 <= s_tdata[63:48];
			data_s1 <= s_tdata[127:64];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			armed_q    <= 1'b0;
			hash_exp_q <= '0;
			len_exp_q  <= LenAll;
			len_rcv_q  <= '0;
			crc_exp_q  <= '0;
			crc_run_q  <= CrcPreset;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				armed_q    <= armed_d;
				hash_exp_q <= hash_exp_d;
				len_exp_q  <= len_exp_d;
				len_rcv_q  <= len_rcv_d;
				crc_exp_q  <= crc_exp_d;
				crc_run_q  <= crc_run_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			flags_s2   <= flags_d;
			done_s2    <= done_d;
			payload_s2 <= payload_d;
			crc_s2     <= crc_out_d;
			rhash_s2   <= rhash_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = flags_s2;
	assign m_tlast  = done_s2;
	assign m_tdata  = {rhash_s2, crc_s2, payload_s2};

endmodule

>>> rtl/csrc16_checker.sv
// checker: port-level properties of the config stream receiver, bound to the top level
module csrc16_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [95:0]         m_tdata,
	input csrc16_pkg::flags_t  m_tuser,
	input logic                m_tlast
);
	import csrc16_pkg::*;

	// a stalled result holds its contents
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("stalled result changed");

	// input side only backs up when the result register is full and stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// an echoed frame is always an accepted item
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser.payload_valid |-> m_tuser.accepted)
		else $error("payload without accept");

	// a good stream is a finished stream
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser.stream_ok |-> m_tlast && m_tuser.payload_valid)
		else $error("stream ok without completion");

	// no stale payload bytes when nothing was appended
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser.payload_valid |-> m_tdata[63:0] == 64'd0)
		else $error("payload not cleared");

endmodule

bind config_stream_receiver_crc16 csrc16_checker u_csrc16_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

>>> test/tb.sv
// testbench for the config stream receiver: scoreboard against a behavioral crc-16 stream model
module tb;
	import csrc16_pkg::*;

	localparam int          CycleLimit  = 200000;
	localparam logic [2:0]  KindSpareLo = 3'd5;
	localparam logic [2:0]  KindSpareHi = 3'd7;

	typedef struct packed {
		logic        accepted;
		logic        payload_valid;
		logic [63:0] payload;
		logic        done;
		logic        ok;
		logic [15:0] crc;
		logic [15:0] rhash;
	} outcome_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;  // hash[15:0], stream_length[47:16], expected_crc[63:48], frame_data[127:64]
	logic [2:0]   s_tuser;  // kind[2:0]
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;  // payload[63:0], computed_crc[79:64], report_hash[95:80]
	flags_t       m_tuser;  // accepted[0], payload_valid[1], stream_ok[2]
	logic         m_tlast;  // stream_done

	// stream state as the block should hold it
	logic        armed_q  = 1'b0;
	logic [15:0] hash_exp = '0;
	logic [31:0] len_exp  = LenAll;
	logic [31:0] len_rcv  = '0;
	logic [15:0] crc_exp  = '0;
	logic [15:0] crc_run  = CrcPreset;

	outcome_t pending_outcomes[$];
	int       mismatches = 0;
	int       cycle_count = 0;
	int       hold_off_cycles = 0;
	bit       sender_gaps = 1'b1;
	bit       receiver_gaps = 1'b1;

	config_stream_receiver_crc16 uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// crc-16 over eight bytes, first byte from the top of the word, msb first
	function automatic logic [15:0] crc_fold8(input logic [15:0] acc, input logic [63:0] data);
		logic [15:0] r;
		r = acc;
		for (int b = 7; b >= 0; b--) begin
			r = r ^ {data[8*b +: 8], 8'h00};
			for (int k = 0; k < 8; k++) begin
				r = r[15] ? ((r << 1) ^ CrcPoly) : (r << 1);
			end
		end
		return r;
	endfunction

	task automatic predict_outcome(input logic [2:0] kind, input logic [15:0] hash,
			input logic [31:0] slen, input logic [15:0] ecrc, input logic [63:0] data);
		outcome_t o;
		logic     completed;
		o = '0;
		completed = 1'b0;
		if (kind <= KIND_ERROR) begin
			o.rhash = hash;
		end
		case (kind)
			KIND_SET_HASH: begin
				hash_exp = hash;
				o.accepted = 1'b1;
			end
			KIND_START: begin
				hash_exp = hash;
				len_exp = slen;
				len_rcv = '0;
				crc_exp = ecrc;
				crc_run = CrcPreset;
				armed_q = 1'b1;
				o.accepted = 1'b1;
			end
			KIND_DATA: begin
				if (armed_q && hash == hash_exp) begin
					o.accepted = 1'b1;
					o.payload_valid = 1'b1;
					o.payload = data;
					crc_run = crc_fold8(crc_run, data);
					if (len_rcv > LenAll - LenStep) begin
						len_rcv = LenAll;
					end else begin
						len_rcv = len_rcv + LenStep;
					end
					if (len_rcv >= len_exp) begin
						armed_q = 1'b0;
						o.done = 1'b1;
						o.ok = (crc_run == crc_exp);
						len_rcv = '0;
						o.crc = crc_run;
						crc_run = CrcPreset;
						completed = 1'b1;
					end
				end
			end
			KIND_ERROR: begin
				if (armed_q && hash == hash_exp) begin
					armed_q = 1'b0;
					len_exp = '0;
					hash_exp = '0;
					o.done = 1'b1;
					o.accepted = 1'b1;
				end
			end
			KIND_REQUEST: begin
				len_rcv = '0;
				len_exp = LenAll;
				crc_run = CrcPreset;
				o.accepted = 1'b1;
			end
			default: begin
			end
		endcase
		if (!completed) begin
			o.crc = crc_run;
		end
		pending_outcomes = {pending_outcomes, o};
	endtask

	// one input transfer; valid stays high when the next item follows without a gap
	task automatic send_item(input logic [2:0] kind, input logic [15:0] hash,
			input logic [31:0] slen, input logic [15:0] ecrc, input logic [63:0] data);
		int gap;
		gap = sender_gaps ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {data, ecrc, slen, hash};
		do @(posedge clk); while (!s_tready);
		predict_outcome(kind, hash, slen, ecrc, data);
	endtask

	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	task automatic send_random_item(input logic [15:0] hash);
		send_item(3'($urandom_range(0, 7)), hash, $urandom, 16'($urandom_range(0, 65535)),
			{$urandom, $urandom});
	endtask

	// disturbance inside a stream: foreign hashes, spare kinds, anything at all
	task automatic send_noise(input logic [15:0] h);
		logic [15:0] other;
		other = h ^ 16'($urandom_range(1, 65535));
		case ($urandom_range(0, 4))
			0: send_item(KIND_DATA, other, $urandom, 16'($urandom_range(0, 65535)),
				{$urandom, $urandom});
			1: send_item(KIND_ERROR, other, $urandom, 16'($urandom_range(0, 65535)),
				{$urandom, $urandom});
			2: send_item(3'($urandom_range(KindSpareLo, KindSpareHi)), h, $urandom,
				16'($urandom_range(0, 65535)), {$urandom, $urandom});
			3: send_item(KIND_SET_HASH, h, $urandom, 16'($urandom_range(0, 65535)),
				{$urandom, $urandom});
			default: send_random_item($urandom_range(0, 3) == 0 ? h : other);
		endcase
	endtask

	// start, frames and an optional abort or restart, with random content
	task automatic run_stream(input bit noisy);
		logic [63:0] frames[6];
		logic [15:0] h;
		logic [15:0] crc_good;
		logic [15:0] crc_sent;
		logic [31:0] slen;
		int          n;
		int          style;
		int          cut_at;
		n = $urandom_range(1, 6);
		h = 16'($urandom_range(0, 65535));
		crc_good = CrcPreset;
		for (int i = 0; i < n; i++) begin
			frames[i] = {$urandom, $urandom};
			crc_good = crc_fold8(crc_good, frames[i]);
		end
		style = $urandom_range(0, 9);
		cut_at = $urandom_range(0, n - 1);
		slen = 32'(8 * n - $urandom_range(0, 7));
		if (style == 0) begin
			slen = '0;
		end else if (style == 1) begin
			slen = $urandom;
		end
		crc_sent = ($urandom_range(0, 3) == 0) ? crc_good ^ 16'($urandom_range(1, 65535))
			: crc_good;
		send_item(KIND_START, h, slen, crc_sent, {$urandom, $urandom});
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 9) == 0) begin
				send_noise(h);
			end
			if (i == cut_at && style == 2) begin
				send_item(KIND_ERROR, h, $urandom, 16'($urandom_range(0, 65535)),
					{$urandom, $urandom});
			end else if (i == cut_at && style == 3) begin
				send_item(KIND_REQUEST, h, $urandom, 16'($urandom_range(0, 65535)),
					{$urandom, $urandom});
			end
			send_item(KIND_DATA, h, $urandom, 16'($urandom_range(0, 65535)), frames[i]);
		end
		if (style == 1 || style == 3) begin
			send_item(KIND_ERROR, h, $urandom, 16'($urandom_range(0, 65535)),
				{$urandom, $urandom});
		end
	endtask

	task automatic test_directed();
		logic [63:0] fa;
		logic [63:0] fb;
		logic [15:0] crc_ones_zero;
		fa = {$urandom, $urandom};
		fb = {$urandom, $urandom};
		crc_ones_zero = crc_fold8(crc_fold8(CrcPreset, '1), '0);
		send_item(KIND_SET_HASH, 16'h0000, '0, '0, '0);
		send_item(KIND_SET_HASH, 16'hFFFF, '1, '1, '1);
		// nothing armed yet: data and error are dropped
		send_item(KIND_DATA, 16'hFFFF, '1, '1, '1);
		send_item(KIND_ERROR, 16'hFFFF, '1, '1, '1);
		for (int k = KindSpareLo; k <= KindSpareHi; k++) begin
			send_item(3'(k), 16'hFFFF, '1, '1, '1);
		end
		// zero length: the first matching frame ends the stream
		send_item(KIND_START, 16'hFFFF, '0, '0, '1);
		send_item(KIND_DATA, 16'h0000, '0, '0, '1);
		send_item(KIND_ERROR, 16'h0000, '0, '0, '0);
		send_item(KIND_DATA, 16'hFFFF, '0, '0, '0);
		// a request mid-stream restarts counting, so the restarted stream is sent again
		send_item(KIND_START, 16'h1234, 32'd16, crc_ones_zero, '0);
		send_item(KIND_REQUEST, 16'h1234, '0, '0, '0);
		send_item(KIND_START, 16'h1234, 32'd16, crc_ones_zero, '0);
		send_item(KIND_DATA, 16'h1234, '0, '0, '1);
		send_item(KIND_DATA, 16'h1234, '0, '0, '0);
		// matching error aborts, later data is dropped
		send_item(KIND_START, 16'hABCD, LenAll, 16'hFFFF, '0);
		send_item(KIND_DATA, 16'hABCD, '0, '0, fa);
		send_item(KIND_ERROR, 16'hABCD, '0, '0, '0);
		send_item(KIND_DATA, 16'hABCD, '0, '0, fa);
		send_item(KIND_REQUEST, 16'h0000, '1, '1, '1);
		// length not a multiple of eight
		send_item(KIND_START, 16'h5A5A, 32'd12, crc_fold8(crc_fold8(CrcPreset, fa), fb), '0);
		send_item(KIND_DATA, 16'h5A5A, '0, '0, fa);
		send_item(KIND_DATA, 16'h5A5A, '0, '0, fb);
	endtask

	task automatic test_random_streams();
		repeat (80) run_stream(1'b1);
	endtask

	task automatic test_no_idle();
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		repeat (30) run_stream(1'b1);
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
	endtask

	// the receiver holds off while items keep coming, so the input side stalls
	task automatic test_backpressure();
		sender_gaps = 1'b0;
		hold_off_cycles = 300;
		repeat (10) run_stream(1'b0);
		sender_gaps = 1'b1;
	endtask

	task automatic test_drain_between_streams();
		repeat (10) begin
			run_stream(1'b0);
			pause_until_drained();
		end
	endtask

	task automatic test_random_items();
		logic [15:0] pool[2];
		pool[0] = 16'($urandom_range(0, 65535));
		pool[1] = 16'($urandom_range(0, 65535));
		repeat (250) begin
			send_random_item(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
				: pool[1'($urandom_range(0, 1))]);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_streams();
		test_no_idle();
		test_backpressure();
		test_drain_between_streams();
		test_random_items();
		pause_until_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// result side: random stalls per transfer, plus a long hold-off when asked
	initial begin
		int n;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end
			n = receiver_gaps ? $urandom_range(0, 7) : 0;
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		outcome_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.accepted = m_tuser.accepted;
			got.payload_valid = m_tuser.payload_valid;
			got.payload = m_tdata[63:0];
			got.done = m_tlast;
			got.ok = m_tuser.stream_ok;
			got.crc = m_tdata[79:64];
			got.rhash = m_tdata[95:80];
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result transfer: %h", got);
				end
			end else begin
				want = pending_outcomes.pop_front();
				if (want !== got) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected acc %b pv %b payload %h done %b ok %b crc %h hash %h",
							want.accepted, want.payload_valid, want.payload, want.done,
							want.ok, want.crc, want.rhash);
						$display("          actual   acc %b pv %b payload %h done %b ok %b crc %h hash %h",
							got.accepted, got.payload_valid, got.payload, got.done,
							got.ok, got.crc, got.rhash);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule

>>> config_stream_receiver_crc16.f
rtl/csrc16_pkg.sv
rtl/config_stream_receiver_crc16.sv
rtl/csrc16_checker.sv
test/tb.sv
